>>> design/gstg_pkg.sv
package gstg_pkg;

  localparam int SINE_TABLE_BITS_DEF = 10;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TONE_INCREMENT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_AMPLITUDE      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RAMP_STEP      = 2'd2;

  localparam logic [31:0] TONE_INCREMENT_RST = 32'd42852281;
  localparam logic [14:0] AMPLITUDE_RST      = 15'd8192;
  localparam logic [15:0] RAMP_STEP_RST      = 16'd328;

  // full scale envelope, 1.0 in q1.15
  localparam logic [15:0] ENV_FULL = 16'd32768;

  localparam int SINE_W = 15;
  localparam int OP_A_W = 30;
  localparam int OP_B_W = 16;
  localparam int PROD_W = OP_A_W + OP_B_W;

  // half of one output lsb in the q45 product
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << 29);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              en;
    logic [OP_A_W-1:0] op_a;
    logic [OP_B_W-1:0] op_b;
  } mul_req_t;

  // quarter wave entry sin(k*pi/(2q)), q = 2^(bits-2), q30 taylor series to x^11
  function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned k,
                                                     input int unsigned bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    x    = (64'(k) * HALF_PI_Q30) >> (bits - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    r = ($unsigned(sum) + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[SINE_W-1:0];
  endfunction

endpackage

>>> design/gstg_sine_rom.sv
module gstg_sine_rom #(
  parameter int TABLE_BITS = gstg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [TABLE_BITS-2:0]       rd_addr,
  output logic [gstg_pkg::SINE_W-1:0] rd_data
);

  localparam int QUARTER = 1 << (TABLE_BITS - 2);

  // quarter wave, both ends included
  logic [gstg_pkg::SINE_W-1:0] rom_data [QUARTER+1];

  for (genvar i = 0; i <= QUARTER; i++) begin : g_entry
    localparam logic [gstg_pkg::SINE_W-1:0] ENTRY = gstg_pkg::quarter_sine(i, TABLE_BITS);
    assign rom_data[i] = ENTRY;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= rom_data[rd_addr];
    end
  end

endmodule

>>> design/gstg_mult_unit.sv
module gstg_mult_unit (
  input  logic                        clk,
  input  gstg_pkg::mul_req_t          req,
  output logic [gstg_pkg::PROD_W-1:0] product
);

  always_ff @(posedge clk) begin
    if (req.en) begin
      product <= gstg_pkg::PROD_W'(req.op_a) * gstg_pkg::PROD_W'(req.op_b);
    end
  end

endmodule

>>> design/gated_sine_tone_generator_top.sv
// gated sine tone generator: one audio sample per input transfer
// cfg channel: cfg_index selects tone_increment (0), amplitude (1) or ramp_step (2),
//   cfg_data carries the value; cfg_ready is always high, other indexes are dropped;
//   write only while the block is idle
// s_axis: tdata[0] is gate_open, tlast is block_end; each transfer asks for one sample
// m_axis: tdata is the signed q1.15 sample, tlast copies block_end
// on an input transfer the envelope steps and the sine rom is read; the shared
// multiplier then forms sine * amplitude in S_MUL1 and that product * envelope in S_MUL2,
// and the rounded sample is loaded into the output register in S_DONE
// the sequencer finishes one sample before it takes the next input, since both passes
//   go through the single shared multiplier
// s_axis_tready is high only while the sequencer is idle; a new item is taken while
// the previous sample still waits in the output register
// when the receiver stalls, the finishing item waits in its last step until the
// output register frees up
// reset: registers back to their defaults, phase and envelope to zero, no output
module gated_sine_tone_generator_top #(
  parameter int SINE_TABLE_BITS = gstg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gstg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [0] gate_open, [7:1] zero
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [15:0]                      m_axis_tdata,  // [15:0] sample_value
  output logic                             m_axis_tlast
);

  localparam int QB = SINE_TABLE_BITS - 2;

  gstg_pkg::state_t state, state_next;

  logic [31:0] tone_increment;
  logic [14:0] amplitude;
  logic [15:0] ramp_step;
  logic [31:0] phase;
  logic [15:0] env, env_next;
  logic        neg;
  logic        last;

  logic                        in_xfer;
  logic                        out_load;
  gstg_pkg::mul_req_t          mul_req;
  logic [gstg_pkg::PROD_W-1:0] product;
  logic [gstg_pkg::PROD_W-1:0] rounded;
  logic [15:0]                 mag;
  logic [15:0]                 sample;
  logic [gstg_pkg::SINE_W-1:0] rom_q;

  logic [SINE_TABLE_BITS-1:0] idx;
  logic [QB-1:0]              pos;
  logic [QB:0]                rom_addr;
  logic [16:0]                env_sum;

  assign cfg_ready = 1'b1;
  assign in_xfer   = s_axis_tvalid && s_axis_tready;

  // quarter wave addressing, odd quadrants mirrored
  assign idx      = phase[31 -: SINE_TABLE_BITS];
  assign pos      = idx[QB-1:0];
  assign rom_addr = idx[QB] ? ((QB+1)'(1) << QB) - {1'b0, pos} : {1'b0, pos};

  gstg_sine_rom #(
    .TABLE_BITS(SINE_TABLE_BITS)
  ) u_rom (
    .clk    (clk),
    .rd_en  (in_xfer),
    .rd_addr(rom_addr),
    .rd_data(rom_q)
  );

  gstg_mult_unit u_mult (
    .clk    (clk),
    .req    (mul_req),
    .product(product)
  );

  // envelope ramp with saturation at both ends
  assign env_sum = {1'b0, env} + {1'b0, ramp_step};
  always_comb begin
    env_next = env;
    if (s_axis_tdata[0] && env < gstg_pkg::ENV_FULL) begin
      env_next = (env_sum > {1'b0, gstg_pkg::ENV_FULL}) ? gstg_pkg::ENV_FULL : env_sum[15:0];
    end else if (!s_axis_tdata[0] && env != 16'd0) begin
      env_next = (ramp_step >= env) ? 16'd0 : env - ramp_step;
    end
  end

  // round half up on the magnitude, then apply the sign
  assign rounded = product + gstg_pkg::ROUND_HALF;
  assign mag     = rounded[45:30];
  assign sample  = neg ? 16'd0 - mag : mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gstg_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    mul_req.en    = 1'b0;
    mul_req.op_a  = gstg_pkg::OP_A_W'(rom_q);
    mul_req.op_b  = gstg_pkg::OP_B_W'(amplitude);
    case (state)
      gstg_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = gstg_pkg::S_MUL1;
        end
      end
      gstg_pkg::S_MUL1: begin
        mul_req.en = 1'b1;
        state_next = gstg_pkg::S_MUL2;
      end
      gstg_pkg::S_MUL2: begin
        mul_req.en   = 1'b1;
        mul_req.op_a = product[gstg_pkg::OP_A_W-1:0];
        mul_req.op_b = env;
        state_next   = gstg_pkg::S_DONE;
      end
      gstg_pkg::S_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = gstg_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = gstg_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_increment <= gstg_pkg::TONE_INCREMENT_RST;
      amplitude      <= gstg_pkg::AMPLITUDE_RST;
      ramp_step      <= gstg_pkg::RAMP_STEP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        gstg_pkg::CFG_TONE_INCREMENT: tone_increment <= cfg_data;
        gstg_pkg::CFG_AMPLITUDE:      amplitude      <= cfg_data[14:0];
        gstg_pkg::CFG_RAMP_STEP:      ramp_step      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // rom reads the old phase on the same edge as the phase steps
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 32'd0;
      env   <= 16'd0;
    end else if (in_xfer) begin
      phase <= phase + tone_increment;
      env   <= env_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      neg  <= idx[QB+1];
      last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= sample;
      m_axis_tlast <= last;
    end
  end

  a_env_bound: assert property (@(posedge clk) disable iff (rst)
    env <= gstg_pkg::ENV_FULL)
    else $error("envelope above full scale");

  a_seq_len: assert property (@(posedge clk) disable iff (rst)
    in_xfer |-> ##3 (state == gstg_pkg::S_DONE))
    else $error("sequencer did not reach its last step in three cycles");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == gstg_pkg::S_DONE))
    else $error("output loaded outside the last step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == gstg_pkg::S_DONE && m_axis_tvalid && !m_axis_tready)
      |=> (state == gstg_pkg::S_DONE))
    else $error("waiting sample overwritten");

endmodule
